>>> rtl/coo_spmv_pkg.sv
// shared types and constants for the coo sparse matrix-vector multiply block
package coo_spmv_pkg;

	localparam int MAX_ROWS = 1024;
	localparam int MAX_COLS = 1024;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int SIZE_W   = 11;
	localparam int VAL_W    = 32;
	localparam int PROD_W   = 2 * VAL_W;
	localparam int FRAC_W   = 16;
	localparam int Y_W      = 48;
	localparam int CFG_W    = 32;
	localparam int ADDR_W   = 3;
	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 48;

	localparam logic [SIZE_W-1:0] RESET_ROWS = SIZE_W'(MAX_ROWS);
	localparam logic [SIZE_W-1:0] RESET_COLS = SIZE_W'(MAX_COLS);

	typedef enum logic [1:0] {
		ACT_LOAD_X = 2'd0,
		ACT_ACCUM  = 2'd1,
		ACT_READ_Y = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_RANGE = 2'd1,
		STS_SAT   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_MUL,
		S_ACC,
		S_DONE
	} state_t;

	typedef enum logic {
		REG_NUM_ROWS = 1'b0,
		REG_NUM_COLS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic load;
		logic x_wr;
		logic rd;
		logic mul;
		logic y_zero;
		logic y_acc;
		logic clr_wr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       row_ok;
		logic       col_ok;
		logic       clr_last;
		logic       out_busy;
	} sts_t;

endpackage

>>> rtl/coo_spmv_ram.sv
// generic simple dual-port ram with registered read
module coo_spmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/coo_spmv_ctrl.sv
// controller state machine: clearing pass, item sequencing and result hand-off
module coo_spmv_ctrl import coo_spmv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = S_READ;
				end
			end
			S_READ: begin
				state_nxt = S_DONE;
				case (sts.action)
					ACT_LOAD_X: begin
						cmd.x_wr = sts.col_ok;
					end
					ACT_ACCUM: begin
						if (sts.row_ok && sts.col_ok) begin
							cmd.rd    = 1'b1;
							state_nxt = S_MUL;
						end
					end
					ACT_READ_Y: begin
						if (sts.row_ok) begin
							cmd.rd    = 1'b1;
							state_nxt = S_MUL;
						end
					end
					default: begin
						state_nxt = S_DONE;
					end
				endcase
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				if (sts.action == ACT_READ_Y) begin
					// read and clear: the entry is zeroed as soon as it is captured
					cmd.y_zero = 1'b1;
					state_nxt  = S_DONE;
				end else begin
					state_nxt = S_ACC;
				end
			end
			S_ACC: begin
				cmd.y_acc = 1'b1;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/coo_spmv_dp.sv
// datapath: x and y stores, multiplier, saturating accumulator and output register
module coo_spmv_dp import coo_spmv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic [1:0]          s_tuser,
	input  logic [SIZE_W-1:0]   num_rows,
	input  logic [SIZE_W-1:0]   num_cols,
	input  cmd_t                cmd,
	output sts_t                sts,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,
	output logic [1:0]          m_tuser
);

	logic [1:0]        action_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [VAL_W-1:0]  value_q;
	logic              row_ok_q;
	logic              col_ok_q;
	logic              sat_q;
	logic [ROW_W-1:0]  clr_cnt_q;
	logic [PROD_W-1:0] prod_q;
	logic [Y_W-1:0]    y_q;
	logic              out_valid_q;
	logic [Y_W-1:0]    out_y_q;
	logic [1:0]        out_status_q;

	logic [ROW_W-1:0]  in_row;
	logic [COL_W-1:0]  in_col;
	logic [SIZE_W-1:0] eff_rows;
	logic [SIZE_W-1:0] eff_cols;
	logic [VAL_W-1:0]  x_rdata;
	logic [Y_W-1:0]    y_rdata;
	logic              y_we;
	logic [ROW_W-1:0]  y_waddr;
	logic [Y_W-1:0]    y_wdata;
	logic [Y_W-1:0]    prod_sh;
	logic [Y_W:0]      sum;
	logic              sum_ovf;
	logic [Y_W-1:0]    sum_sat;
	status_t           res_status;
	logic [Y_W-1:0]    res_y;

	assign in_row = s_tdata[ROW_W-1:0];
	assign in_col = s_tdata[ROW_W +: COL_W];

	assign eff_rows = (num_rows < SIZE_W'(MAX_ROWS)) ? num_rows : SIZE_W'(MAX_ROWS);
	assign eff_cols = (num_cols < SIZE_W'(MAX_COLS)) ? num_cols : SIZE_W'(MAX_COLS);

	// item capture and range flags
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= s_tuser;
			row_q    <= in_row;
			col_q    <= in_col;
			value_q  <= s_tdata[ROW_W + COL_W +: VAL_W];
			row_ok_q <= SIZE_W'(in_row) < eff_rows;
			col_ok_q <= SIZE_W'(in_col) < eff_cols;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(signed'(value_q) * signed'(x_rdata));
			y_q    <= y_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q     <= 1'b0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				sat_q <= 1'b0;
			end else if (cmd.y_acc) begin
				sat_q <= sum_ovf;
			end
			if (cmd.clr_wr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	coo_spmv_ram #(
		.WIDTH (VAL_W),
		.DEPTH (MAX_COLS)
	) u_x_ram (
		.clk   (clk),
		.we    (cmd.x_wr),
		.waddr (col_q),
		.wdata (value_q),
		.re    (cmd.rd),
		.raddr (col_q),
		.rdata (x_rdata)
	);

	// floor shift of the q32.32 product down to q32.16
	assign prod_sh = prod_q[FRAC_W +: Y_W];
	assign sum     = {y_q[Y_W-1], y_q} + {prod_sh[Y_W-1], prod_sh};
	assign sum_ovf = sum[Y_W] != sum[Y_W-1];

	always_comb begin
		if (!sum_ovf) begin
			sum_sat = sum[Y_W-1:0];
		end else if (sum[Y_W]) begin
			sum_sat = {1'b1, {(Y_W-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(Y_W-1){1'b1}}};
		end
	end

	assign y_we    = cmd.clr_wr | cmd.y_zero | cmd.y_acc;
	assign y_waddr = cmd.clr_wr ? clr_cnt_q : row_q;
	assign y_wdata = cmd.y_acc ? sum_sat : '0;

	coo_spmv_ram #(
		.WIDTH (Y_W),
		.DEPTH (MAX_ROWS)
	) u_y_ram (
		.clk   (clk),
		.we    (y_we),
		.waddr (y_waddr),
		.wdata (y_wdata),
		.re    (cmd.rd),
		.raddr (row_q),
		.rdata (y_rdata)
	);

	always_comb begin
		res_y = '0;
		case (action_q)
			ACT_LOAD_X: begin
				res_status = col_ok_q ? STS_OK : STS_RANGE;
			end
			ACT_ACCUM: begin
				if (row_ok_q && col_ok_q) begin
					res_status = sat_q ? STS_SAT : STS_OK;
				end else begin
					res_status = STS_RANGE;
				end
			end
			ACT_READ_Y: begin
				res_status = row_ok_q ? STS_OK : STS_RANGE;
				if (row_ok_q) begin
					res_y = y_q;
				end
			end
			default: begin
				res_status = STS_OK;
			end
		endcase
	end

	// output register lets the next item in while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_y_q      <= res_y;
			out_status_q <= res_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_y_q;
	assign m_tuser  = out_status_q;

	assign sts.action   = action_q;
	assign sts.row_ok   = row_ok_q;
	assign sts.col_ok   = col_ok_q;
	assign sts.clr_last = clr_cnt_q == ROW_W'(MAX_ROWS - 1);
	assign sts.out_busy = out_valid_q && !m_tready;

endmodule

>>> rtl/coo_sparse_matrix_vector_multiply.sv
// top level: coo sparse matrix-vector multiply with apb size registers
// steps: ram read, multiply and add for accumulate; read and multiply for read-and-clear;
// load-x and out-of-range items skip to done; a new item is taken only after the result is loaded
// the output register holds a finished result while the next item is taken in
// reset: asynchronous, active low; sizes return to 1024 and y is cleared by a
// pass over all 1024 entries, one entry a cycle, before the first item is accepted
module coo_sparse_matrix_vector_multiply import coo_spmv_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // row_index, col_index, entry_value, zero pad
	input  logic [1:0]          s_tuser,   // action
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // y_value
	output logic [1:0]          m_tuser,   // status
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [CFG_W-1:0]    pwdata,
	output logic [CFG_W-1:0]    prdata,
	output logic                pready
);

	logic [SIZE_W-1:0] num_rows_q;
	logic [SIZE_W-1:0] num_cols_q;
	logic              cfg_wr;
	reg_idx_t          reg_idx;
	cmd_t              cmd;
	sts_t              sts;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= RESET_ROWS;
			num_cols_q <= RESET_COLS;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_NUM_ROWS: num_rows_q <= pwdata[SIZE_W-1:0];
				REG_NUM_COLS: num_cols_q <= pwdata[SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_NUM_ROWS: prdata = CFG_W'(num_rows_q);
			REG_NUM_COLS: prdata = CFG_W'(num_cols_q);
			default:      prdata = '0;
		endcase
	end

	coo_spmv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	coo_spmv_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.num_rows (num_rows_q),
		.num_cols (num_cols_q),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
